// File: rtl/zbsps_pkg.sv
// zbsps_pkg: shared types and codes for the z-buffered point splatter.
// Word layouts, operation codes, register indexes, pixel store entry format.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package zbsps_pkg;

  localparam int CW        = 7;   // pixel coordinate width (active size <= 127)
  localparam int RADW      = 3;   // radius width
  localparam int ZW        = 24;  // depth width
  localparam int CHW       = 8;   // color channel width
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 8;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_SPLAT = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_RED       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_GREEN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_BLUE      = 3'd5;

  typedef struct packed {
    logic [1:0]        operation;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic              in_front;
    logic [ZW-1:0]     point_depth;
    logic [CHW-1:0]    point_red;
    logic [CHW-1:0]    point_green;
    logic [CHW-1:0]    point_blue;
  } in_word_t;

  typedef struct packed {
    logic [CHW-1:0] out_red;
    logic [CHW-1:0] out_green;
    logic [CHW-1:0] out_blue;
    logic           covered;
  } out_word_t;

  // active (clamped) frame settings
  typedef struct packed {
    logic [CW-1:0]    width;
    logic [CW-1:0]    height;
    logic [RADW-1:0]  radius;
    logic [3*CHW-1:0] bg;
  } frame_cfg_t;

  typedef struct packed {
    logic           written;
    logic [ZW-1:0]  depth;
    logic [3*CHW-1:0] color;
  } pix_entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

// File: rtl/zbsps_cfg.sv
// zbsps_cfg: configuration register file with range clamping.
// Depends on zbsps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zbsps_cfg #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_RADIUS = 7
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [zbsps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [zbsps_pkg::CFG_DW-1:0]       cfg_data,
  output zbsps_pkg::frame_cfg_t                   fcfg
);

  logic [zbsps_pkg::CW-1:0]   width_r,  width_nxt;
  logic [zbsps_pkg::CW-1:0]   height_r, height_nxt;
  logic [zbsps_pkg::RADW-1:0] radius_r, radius_nxt;
  logic [zbsps_pkg::CHW-1:0]  red_r,    red_nxt;
  logic [zbsps_pkg::CHW-1:0]  green_r,  green_nxt;
  logic [zbsps_pkg::CHW-1:0]  blue_r,   blue_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    radius_nxt = radius_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    blue_nxt   = blue_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        zbsps_pkg::CFG_FRAME_WIDTH:  width_nxt  = cfg_data[zbsps_pkg::CW-1:0];
        zbsps_pkg::CFG_FRAME_HEIGHT: height_nxt = cfg_data[zbsps_pkg::CW-1:0];
        zbsps_pkg::CFG_POINT_RADIUS: radius_nxt = cfg_data[zbsps_pkg::RADW-1:0];
        zbsps_pkg::CFG_BG_RED:       red_nxt    = cfg_data;
        zbsps_pkg::CFG_BG_GREEN:     green_nxt  = cfg_data;
        zbsps_pkg::CFG_BG_BLUE:      blue_nxt   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 7'd64;
      height_r <= 7'd64;
      radius_r <= 3'd1;
      red_r    <= '0;
      green_r  <= '0;
      blue_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      radius_r <= radius_nxt;
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      blue_r   <= blue_nxt;
    end
  end

  always_comb begin
    if (width_r == '0) begin
      fcfg.width = zbsps_pkg::CW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      fcfg.width = zbsps_pkg::CW'(MAX_WIDTH);
    end else begin
      fcfg.width = width_r;
    end
    if (height_r == '0) begin
      fcfg.height = zbsps_pkg::CW'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      fcfg.height = zbsps_pkg::CW'(MAX_HEIGHT);
    end else begin
      fcfg.height = height_r;
    end
    if (32'(radius_r) > MAX_RADIUS) begin
      fcfg.radius = zbsps_pkg::RADW'(MAX_RADIUS);
    end else begin
      fcfg.radius = radius_r;
    end
    fcfg.bg = {red_r, green_r, blue_r};
  end

endmodule

`default_nettype wire

// File: rtl/zbsps_mem.sv
// zbsps_mem: pixel store, one write and one registered read port.
// Entry holds written flag, depth and color. Depends on zbsps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zbsps_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                  clk,
  input  wire zbsps_pkg::mem_ctl_t   mem_ctl,
  input  wire logic [AW-1:0]         rd_addr,
  output zbsps_pkg::pix_entry_t      rd_data,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire zbsps_pkg::pix_entry_t wr_data
);

  zbsps_pkg::pix_entry_t store_r [DEPTH];
  zbsps_pkg::pix_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/zbsps_ctrl.sv
// zbsps_ctrl: operation sequencer. Clear sweep, splat scan with pipelined
// depth-test read-modify-write, pixel read, result register.
// Depends on zbsps_pkg; drives zbsps_mem.
`timescale 1ns / 1ps
`default_nettype none

module zbsps_ctrl #(
  parameter int MAX_WIDTH = 64,
  parameter int DEPTH     = 4096,
  parameter int AW        = 12,
  parameter int FRAC_BITS = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire zbsps_pkg::in_word_t    in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output zbsps_pkg::out_word_t        out_data,
  input  wire zbsps_pkg::frame_cfg_t  fcfg,
  output zbsps_pkg::mem_ctl_t         mem_ctl,
  output logic [AW-1:0]               mem_rd_addr,
  input  wire zbsps_pkg::pix_entry_t  mem_rd_data,
  output logic [AW-1:0]               mem_wr_addr,
  output zbsps_pkg::pix_entry_t       mem_wr_data
);

  localparam int CW = zbsps_pkg::CW;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SETUP  = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_RFETCH = 3'd5;
  localparam logic [2:0] ST_RDONE  = 3'd6;

  logic [2:0]           state_r,   state_nxt;
  zbsps_pkg::in_word_t  item_r,    item_nxt;
  logic [AW-1:0]        sweep_r,   sweep_nxt;
  logic [CW-1:0]        x_r,       x_nxt;
  logic [CW-1:0]        y_r,       y_nxt;
  logic [CW-1:0]        x0_r,      x0_nxt;
  logic [CW-1:0]        x1_r,      x1_nxt;
  logic [CW-1:0]        y1_r,      y1_nxt;
  logic                 inrange_r, inrange_nxt;
  logic                 rmw_v_r,   rmw_v_nxt;
  logic [AW-1:0]        rmw_addr_r;
  logic                 out_valid_r, out_valid_nxt;
  zbsps_pkg::out_word_t out_data_r,  out_data_nxt;

  logic signed [15:0] cx, cy;
  logic signed [17:0] cx_e, cy_e, r_e, w_e, h_e;
  logic signed [17:0] x0_e, x1_e, y0_e, y1_e;
  logic [CW-1:0]      x0c, x1c, y0c, y1c;
  logic               drop, rd_in, out_free;

  // splat bounds and read range check, from the held item
  always_comb begin
    cx   = item_r.pixel_x >>> FRAC_BITS;
    cy   = item_r.pixel_y >>> FRAC_BITS;
    cx_e = $signed({{2{cx[15]}}, cx});
    cy_e = $signed({{2{cy[15]}}, cy});
    r_e  = $signed({{(18-zbsps_pkg::RADW){1'b0}}, fcfg.radius});
    w_e  = $signed({{(18-CW){1'b0}}, fcfg.width});
    h_e  = $signed({{(18-CW){1'b0}}, fcfg.height});
    drop = !item_r.in_front
        || (cx_e < 18'sd0 - r_e) || (cx_e >= w_e + r_e)
        || (cy_e < 18'sd0 - r_e) || (cy_e >= h_e + r_e);
    x0_e = cx_e - r_e;
    x1_e = cx_e + r_e;
    y0_e = cy_e - r_e;
    y1_e = cy_e + r_e;
    x0c  = x0_e[17] ? '0 : x0_e[CW-1:0];
    y0c  = y0_e[17] ? '0 : y0_e[CW-1:0];
    x1c  = (x1_e > w_e - 18'sd1) ? fcfg.width - CW'(1)  : x1_e[CW-1:0];
    y1c  = (y1_e > h_e - 18'sd1) ? fcfg.height - CW'(1) : y1_e[CW-1:0];
    rd_in = !item_r.pixel_x[15] && !item_r.pixel_y[15]
         && (item_r.pixel_x[14:0] < {{(15-CW){1'b0}}, fcfg.width})
         && (item_r.pixel_y[14:0] < {{(15-CW){1'b0}}, fcfg.height});
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    sweep_nxt     = sweep_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    inrange_nxt   = inrange_r;
    rmw_v_nxt     = 1'b0;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_CLEAR: begin
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        case (item_r.operation)
          zbsps_pkg::OP_CLEAR: begin
            sweep_nxt = '0;
            state_nxt = ST_CLEAR;
          end
          zbsps_pkg::OP_SPLAT: begin
            if (drop) begin
              state_nxt = ST_IDLE;
            end else begin
              x_nxt     = x0c;
              y_nxt     = y0c;
              x0_nxt    = x0c;
              x1_nxt    = x1c;
              y1_nxt    = y1c;
              state_nxt = ST_SCAN;
            end
          end
          zbsps_pkg::OP_READ: begin
            x_nxt       = item_r.pixel_x[CW-1:0];
            y_nxt       = item_r.pixel_y[CW-1:0];
            inrange_nxt = rd_in;
            state_nxt   = ST_RFETCH;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        rmw_v_nxt = 1'b1;
        if (x_r == x1_r) begin
          x_nxt = x0_r;
          if (y_r == y1_r) begin
            state_nxt = ST_DRAIN;
          end else begin
            y_nxt = y_r + CW'(1);
          end
        end else begin
          x_nxt = x_r + CW'(1);
        end
      end
      ST_DRAIN:  state_nxt = ST_IDLE;
      ST_RFETCH: state_nxt = ST_RDONE;
      ST_RDONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (inrange_r && mem_rd_data.written) begin
            {out_data_nxt.out_red, out_data_nxt.out_green, out_data_nxt.out_blue} =
              mem_rd_data.color;
            out_data_nxt.covered = 1'b1;
          end else begin
            {out_data_nxt.out_red, out_data_nxt.out_green, out_data_nxt.out_blue} =
              fcfg.bg;
            out_data_nxt.covered = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sweep_r     <= '0;
      rmw_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      rmw_v_r     <= rmw_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    inrange_r  <= inrange_nxt;
    rmw_addr_r <= mem_rd_addr;
    out_data_r <= out_data_nxt;
  end

  // memory side: read the current pixel, depth-test and write back in the next cycle
  always_comb begin
    mem_rd_addr   = AW'(32'(y_r) * MAX_WIDTH + 32'(x_r));
    mem_ctl.rd_en = (state_r == ST_SCAN) || ((state_r == ST_RFETCH) && inrange_r);
    if (state_r == ST_CLEAR) begin
      mem_ctl.wr_en = 1'b1;
      mem_wr_addr   = sweep_r;
      mem_wr_data   = '0;
    end else begin
      mem_ctl.wr_en = rmw_v_r
                   && (!mem_rd_data.written || (item_r.point_depth < mem_rd_data.depth));
      mem_wr_addr   = rmw_addr_r;
      mem_wr_data.written = 1'b1;
      mem_wr_data.depth   = item_r.point_depth;
      mem_wr_data.color   = {item_r.point_red, item_r.point_green, item_r.point_blue};
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_ctl.wr_en)
    else $error("pixel store written while idle");

  a_rmw_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rmw_v_r |-> ($past(state_r) == ST_SCAN))
    else $error("write-back stage active without a scan read");

  a_scan_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ((x_r >= x0_r) && (x_r <= x1_r) && (y_r <= y1_r)))
    else $error("scan position left the clipped square");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_ctl.rd_en && mem_ctl.wr_en) |-> (mem_rd_addr != mem_wr_addr))
    else $error("read and write to the same pixel in one cycle");

endmodule

`default_nettype wire

// File: rtl/zbuffer_square_point_splat.sv
// zbuffer_square_point_splat: top level of the z-buffered square point splatter.
// Depends on zbsps_pkg, zbsps_cfg, zbsps_mem, zbsps_ctrl.
//
// Words are handled one at a time through a single pixel store (flag, depth,
// color per pixel) whose read data is registered. A splat is accepted, set
// up, scans each pixel of its clipped square (read, depth test, write-back)
// and ends with a write-back drain. A dropped splat returns to idle after
// setup. A read is accepted, set up, fetched and returned; it waits while the
// result register is held by out_stall. A clear sweeps the whole store at one
// entry per cycle. After reset the same sweep runs before the first word is
// taken; config writes are taken at any time. A read result waits in an
// output register while the next word is accepted.
`timescale 1ns / 1ps
`default_nettype none

module zbuffer_square_point_splat #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_RADIUS = 7,
  parameter int FRAC_BITS  = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire zbsps_pkg::in_word_t             in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output zbsps_pkg::out_word_t                 out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [zbsps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [zbsps_pkg::CFG_DW-1:0]    cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  zbsps_pkg::frame_cfg_t fcfg;
  zbsps_pkg::mem_ctl_t   mem_ctl;
  zbsps_pkg::pix_entry_t mem_rd_data;
  zbsps_pkg::pix_entry_t mem_wr_data;
  logic [AW-1:0]         mem_rd_addr;
  logic [AW-1:0]         mem_wr_addr;

  zbsps_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fcfg      (fcfg)
  );

  zbsps_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .DEPTH     (DEPTH),
    .AW        (AW),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fcfg        (fcfg),
    .mem_ctl     (mem_ctl),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  zbsps_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

endmodule

`default_nettype wire
